// ===== src/spg_pkg.sv =====
// ----------------------------------------------------------------------------
// spg_pkg
// Shared constants, register codes and types of the sine palette generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

  // Field widths
  localparam int unsigned IdxW    = 12;
  localparam int unsigned ColW    = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PhaseW  = 20;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned PaletteSizeDef = 4096;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgStartSet     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIncrementSet = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgThreshold    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCycleOffset  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLogMode      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgInsideColour = 3'd5;

  // Register reset values
  localparam logic [ColW-1:0] StartSetRst     = 24'h1E783C;
  localparam logic [ColW-1:0] IncrementSetRst = 24'hC8FF64;
  localparam logic [IdxW-1:0] ThresholdRst    = 12'd255;
  localparam logic [IdxW-1:0] CycleOffsetRst  = 12'd0;
  localparam logic [ColW-1:0] InsideColourRst = 24'h323232;

  // Phase divider: fractional quotient bits resolved per stage
  localparam int unsigned DivSteps  = 2;
  localparam int unsigned DivStages = PhaseW / DivSteps;

  // Pipeline depths
  localparam int unsigned PhaseLat = 4 + DivStages;
  localparam int unsigned SineLat  = 6;
  localparam int unsigned PipeLat  = 1 + PhaseLat + SineLat;

  // Quarter-wave sine polynomial, Q30
  localparam logic [30:0] Coef1 = 31'd1686629713;
  localparam logic [30:0] Coef3 = 31'd693598671;
  localparam logic [30:0] Coef5 = 31'd85569278;
  localparam logic [30:0] Coef7 = 31'd5026990;

  // Per-item position handed from the front stage to the phase units
  typedef struct packed {
    logic [IdxW-1:0] cycle;
    logic [IdxW-1:0] divisor;
  } spg_front_t;

endpackage

`default_nettype wire

// ===== src/spg_front.sv =====
// ----------------------------------------------------------------------------
// spg_front
// Input stage: clamps threshold and offset, wraps the cycled index.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_front import spg_pkg::*; #(
  parameter int unsigned PALETTE_SIZE = PaletteSizeDef
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [IdxW-1:0] index_i,
  input  wire logic [IdxW-1:0] threshold_i,
  input  wire logic [IdxW-1:0] cycle_offset_i,
  input  wire logic            log_mode_i,
  output spg_front_t           front_o,
  output logic                 inside_o
);

  logic [IdxW-1:0] lim;
  logic [IdxW-1:0] off;
  logic [IdxW:0]   sum;
  logic [IdxW:0]   wrap;
  spg_front_t      front_d;
  spg_front_t      front_q;
  logic            inside_d;
  logic            inside_q;

  // Clamp, add the offset and wrap once
  always_comb begin
    lim  = (32'(threshold_i) >= PALETTE_SIZE) ? IdxW'(PALETTE_SIZE - 1) : threshold_i;
    off  = (cycle_offset_i > lim) ? lim : cycle_offset_i;
    sum  = {1'b0, off} + {1'b0, index_i};
    wrap = (sum > {1'b0, lim}) ? sum - {1'b0, lim} : sum;
    front_d.cycle   = wrap[IdxW-1:0];
    front_d.divisor = log_mode_i ? IdxW'(256) : lim;
    inside_d = (index_i >= lim);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q  <= front_d;
      inside_q <= inside_d;
    end
  end

  assign front_o  = front_q;
  assign inside_o = inside_q;

endmodule

`default_nettype wire

// ===== src/spg_phase.sv =====
// ----------------------------------------------------------------------------
// spg_phase
// One channel's phase: fraction of a turn in Q20, via a pipelined divider.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_phase import spg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire spg_front_t        front_i,
  input  wire logic              log_mode_i,
  input  wire logic [ByteW-1:0]  start_i,
  input  wire logic [ByteW-1:0]  inc_i,
  output logic      [PhaseW-1:0] phase_o
);

  // Stage 1 products
  logic [15:0] a1_q;
  logic [19:0] b1_q;
  logic [11:0] d1_q;
  logic [18:0] hd1_q;
  logic [25:0] den1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= 16'(start_i) * 16'(inc_i);
      b1_q   <= 20'(front_i.cycle) * 20'(inc_i);
      d1_q   <= front_i.divisor;
      hd1_q  <= 19'(front_i.divisor) * 19'd100;
      den1_q <= 26'(front_i.divisor) * 26'd10000;
    end
  end

  // Stage 2: reduce start term mod 10000 and cycle term mod 100*D
  logic [15:0] ra_w;
  logic [11:0] x_w;
  logic [24:0] xq_w;
  logic [11:0] xr_w;
  logic [19:0] rb_w;
  logic [13:0] ra2_q;
  logic [18:0] rb2_q;
  logic [11:0] d2_q;
  logic [25:0] den2_q;

  always_comb begin
    ra_w = a1_q;
    for (int k = 1; k <= 6; k++) begin
      if (a1_q >= 16'(k * 10000)) ra_w = a1_q - 16'(k * 10000);
    end
    // log mode: 100*256 splits into the low byte and a mod-100 of the rest
    x_w  = b1_q[19:8];
    xq_w = 25'(x_w) * 25'd5243;
    xr_w = x_w - 12'(xq_w[24:19]) * 12'd100;
    if (log_mode_i) begin
      rb_w = {5'd0, xr_w[6:0], b1_q[7:0]};
    end else if (b1_q >= {hd1_q, 1'b0}) begin
      rb_w = b1_q - {hd1_q, 1'b0};
    end else if (b1_q >= {1'b0, hd1_q}) begin
      rb_w = b1_q - {1'b0, hd1_q};
    end else begin
      rb_w = b1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ra2_q  <= ra_w[13:0];
      rb2_q  <= rb_w[18:0];
      d2_q   <= d1_q;
      den2_q <= den1_q;
    end
  end

  // Stage 3: combined numerator over 10000*D
  logic [26:0] num3_q;
  logic [25:0] den3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num3_q <= 27'(ra2_q) * 27'(d2_q) + 27'(rb2_q) * 27'd100;
      den3_q <= den2_q;
    end
  end

  // Stage 4: final wrap below one turn, seeds the divider
  logic [25:0]       drem_q [DivStages+1];
  logic [25:0]       dden_q [DivStages+1];
  logic [PhaseW-1:0] dquo_q [DivStages+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drem_q[0] <= (num3_q >= {1'b0, den3_q}) ? 26'(num3_q - {1'b0, den3_q}) : num3_q[25:0];
      dden_q[0] <= den3_q;
      dquo_q[0] <= '0;
    end
  end

  // Restoring division stages, two quotient bits each
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    logic [25:0]       r_w;
    logic [26:0]       t_w;
    logic [PhaseW-1:0] q_w;

    always_comb begin
      r_w = drem_q[s];
      q_w = dquo_q[s];
      t_w = '0;
      for (int j = 0; j < DivSteps; j++) begin
        t_w = {r_w, 1'b0};
        if (t_w >= {1'b0, dden_q[s]}) begin
          r_w = 26'(t_w - {1'b0, dden_q[s]});
          q_w = {q_w[PhaseW-2:0], 1'b1};
        end else begin
          r_w = t_w[25:0];
          q_w = {q_w[PhaseW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[s+1] <= r_w;
        dden_q[s+1] <= dden_q[s];
        dquo_q[s+1] <= q_w;
      end
    end
  end

  assign phase_o = dquo_q[DivStages];

endmodule

`default_nettype wire

// ===== src/spg_sine.sv =====
// ----------------------------------------------------------------------------
// spg_sine
// Phase to channel byte: quarter-wave odd polynomial, at most one multiply per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_sine import spg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [PhaseW-1:0] phase_i,
  output logic      [ByteW-1:0]  byte_o
);

  logic [18:0] fold_w;
  logic [20:0] u_w;
  logic [41:0] sq_w;

  // Fold into the first quadrant
  always_comb begin
    fold_w = 19'h40000 - {1'b0, phase_i[17:0]};
    u_w    = phase_i[18] ? {fold_w, 2'b00} : {1'b0, phase_i[17:0], 2'b00};
    sq_w   = 42'(u_w) * 42'(u_w);
  end

  logic [20:0] u1_q, u2_q, u3_q, u4_q;
  logic [20:0] v1_q, v2_q, v3_q;
  logic        n1_q, n2_q, n3_q, n4_q, n5_q;
  logic [30:0] t2_q, t3_q, t4_q, s5_q;
  logic [51:0] p2_w, p3_w, p4_w, p5_w;

  always_comb begin
    p2_w = 52'(Coef7) * 52'(v1_q);
    p3_w = 52'(t2_q) * 52'(v2_q);
    p4_w = 52'(t3_q) * 52'(v3_q);
    p5_w = 52'(t4_q) * 52'(u4_q);
  end

  // Horner steps, then scale by u
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q <= u_w;
      v1_q <= sq_w[40:20];
      n1_q <= phase_i[19];

      u2_q <= u1_q;
      v2_q <= v1_q;
      n2_q <= n1_q;
      t2_q <= Coef5 - 31'(p2_w >> 20);

      u3_q <= u2_q;
      v3_q <= v2_q;
      n3_q <= n2_q;
      t3_q <= Coef3 - 31'(p3_w >> 20);

      u4_q <= u3_q;
      n4_q <= n3_q;
      t4_q <= Coef1 - 31'(p4_w >> 20);

      n5_q <= n4_q;
      s5_q <= 31'(p5_w >> 20);
    end
  end

  // Scale by 127, truncate, apply sign about 128
  logic [37:0] m_w;
  logic [7:0]  mag_w;
  logic [7:0]  byte_d;
  logic [7:0]  byte_q;

  always_comb begin
    m_w    = {s5_q, 7'd0} - {7'd0, s5_q};
    mag_w  = m_w[37:30];
    if (mag_w > 8'd127) mag_w = 8'd127;
    byte_d = n5_q ? 8'd128 - mag_w : 8'd128 + mag_w;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ===== src/sine_palette_generator.sv =====
// ----------------------------------------------------------------------------
// sine_palette_generator
// Palette index in, 24-bit colour out; one result per clock while the
// output accepts, through one input stage, a 14-stage phase unit per channel
// (products, modular reductions and a 20-bit restoring divider taking two
// quotient bits per stage) and a 6-stage sine polynomial. The pipeline
// advances as a whole and stalls only while a result waits at the output;
// s_axis_tready drops exactly then. Register writes take effect at once
// and must be made while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_palette_generator import spg_pkg::*; #(
  parameter int unsigned PALETTE_SIZE = PaletteSizeDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ColW-1:0]    cfg_data_i,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [15:0]        s_axis_tdata_i,  // [11:0] palette_index
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic      [ColW-1:0]    m_axis_tdata_o,  // [7:0] blue, [15:8] green, [23:16] red
  output logic      [0:0]         m_axis_tuser_o   // [0] is_inside
);

  // Configuration registers
  logic [ColW-1:0] start_set_q, increment_set_q, inside_colour_q;
  logic [IdxW-1:0] threshold_q, cycle_offset_q;
  logic            log_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_set_q     <= StartSetRst;
      increment_set_q <= IncrementSetRst;
      threshold_q     <= ThresholdRst;
      cycle_offset_q  <= CycleOffsetRst;
      log_mode_q      <= 1'b0;
      inside_colour_q <= InsideColourRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgStartSet:     start_set_q     <= cfg_data_i;
        CfgIncrementSet: increment_set_q <= cfg_data_i;
        CfgThreshold:    threshold_q     <= cfg_data_i[IdxW-1:0];
        CfgCycleOffset:  cycle_offset_q  <= cfg_data_i[IdxW-1:0];
        CfgLogMode:      log_mode_q      <= cfg_data_i[0];
        CfgInsideColour: inside_colour_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: move unless a result is held at the output
  logic               en;
  logic [PipeLat-1:0] vld_q;
  logic [PipeLat-1:1] ins_q;

  assign en              = !vld_q[PipeLat-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeLat-2:0], s_axis_tvalid_i};
    end
  end

  spg_front_t front;
  logic       front_ins;

  spg_front #(.PALETTE_SIZE(PALETTE_SIZE)) u_front (
    .clk_i          (clk_i),
    .en_i           (en),
    .index_i        (s_axis_tdata_i[IdxW-1:0]),
    .threshold_i    (threshold_q),
    .cycle_offset_i (cycle_offset_q),
    .log_mode_i     (log_mode_q),
    .front_o        (front),
    .inside_o       (front_ins)
  );

  // Carry the inside flag alongside the channel pipelines
  always_ff @(posedge clk_i) begin
    if (en) ins_q <= {ins_q[PipeLat-2:1], front_ins};
  end

  logic [ByteW-1:0] ch_byte [3];

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [PhaseW-1:0] phase;

    spg_phase u_phase (
      .clk_i      (clk_i),
      .en_i       (en),
      .front_i    (front),
      .log_mode_i (log_mode_q),
      .start_i    (start_set_q[ByteW*c +: ByteW]),
      .inc_i      (increment_set_q[ByteW*c +: ByteW]),
      .phase_o    (phase)
    );

    spg_sine u_sine (
      .clk_i   (clk_i),
      .en_i    (en),
      .phase_i (phase),
      .byte_o  (ch_byte[c])
    );
  end

  // Select inside colour or the sine colour
  assign m_axis_tvalid_o   = vld_q[PipeLat-1];
  assign m_axis_tuser_o[0] = ins_q[PipeLat-1];
  assign m_axis_tdata_o    = ins_q[PipeLat-1] ? inside_colour_q
                                              : {ch_byte[2], ch_byte[1], ch_byte[0]};

endmodule

`default_nettype wire

// ===== src/spg_checker.sv =====
// ----------------------------------------------------------------------------
// spg_checker
// Port-level checks of the sine palette generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_checker import spg_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            s_axis_tready_o,
  input wire logic            m_axis_tvalid_o,
  input wire logic            m_axis_tready_i,
  input wire logic [ColW-1:0] m_axis_tdata_o,
  input wire logic [0:0]      m_axis_tuser_o
);

  // Output valid holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  // An empty output never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  // A held result stalls the input
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  // Sine colours never reach zero
  a_sine_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      m_axis_tdata_o[7:0] != 8'd0 && m_axis_tdata_o[15:8] != 8'd0 &&
      m_axis_tdata_o[23:16] != 8'd0)
    else $error("sine channel byte out of range");

endmodule

bind sine_palette_generator spg_checker u_spg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// ===== tb/sv/sine_palette_checker.sv =====
// ----------------------------------------------------------------------------
// sine_palette_checker
// Watches both streams of the sine palette generator, predicts each colour
// from the register values it sees written, and compares the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module sine_palette_checker import spg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ColW-1:0]    cfg_data_i,
  input  wire logic               s_valid_i,
  input  wire logic               s_ready_i,
  input  wire logic [15:0]        s_data_i,
  input  wire logic               m_valid_i,
  input  wire logic               m_ready_i,
  input  wire logic [ColW-1:0]    m_data_i,
  input  wire logic [0:0]         m_user_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      colours_o,
  output int                      inside_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_inside;
  } colour_t;

  logic [ColW-1:0] start_q, inc_q, inside_q;
  logic [IdxW-1:0] thr_q, off_q;
  logic            log_q;
  colour_t         colour_q[$];

  // Sine byte for a Q20 phase in turns: quarter-wave odd polynomial
  function automatic logic [7:0] sine_byte(input logic [19:0] ph);
    logic [1:0]  quad;
    logic [63:0] rem, u, u2, t, s, mag;
    quad = ph[19:18];
    rem  = {46'd0, ph[17:0]};
    u    = (quad[0] == 1'b0) ? (rem << 2) : ((64'd262144 - rem) << 2);
    u2   = (u * u) >> 20;
    t    = 64'(Coef7);
    t    = 64'(Coef5) - ((t * u2) >> 20);
    t    = 64'(Coef3) - ((t * u2) >> 20);
    t    = 64'(Coef1) - ((t * u2) >> 20);
    s    = (t * u) >> 20;
    mag  = (64'd127 * s) >> 30;
    if (mag > 64'd127) mag = 64'd127;
    return quad[1] ? 8'(64'd128 - mag) : 8'(64'd128 + mag);
  endfunction

  function automatic logic [7:0] channel_byte(input logic [31:0] cyc, input logic [31:0] dv,
                                              input logic [7:0] st, input logic [7:0] inc);
    logic [63:0] num, den, rem, ph;
    num = (64'(cyc) * 100 + 64'(st) * 64'(dv)) * 64'(inc);
    den = 64'(dv) * 10000;
    rem = num % den;
    ph  = (rem << 20) / den;
    return sine_byte(ph[19:0]);
  endfunction

  function automatic colour_t predict_colour(input logic [IdxW-1:0] idx);
    colour_t     c;
    logic [31:0] lim, off, cyc, dv;
    lim = 32'(thr_q);
    if (lim >= 32'd4095) lim = 32'd4095;
    if (32'(idx) >= lim) begin
      c.blue = inside_q[7:0];
      c.green = inside_q[15:8];
      c.red = inside_q[23:16];
      c.is_inside = 1'b1;
      return c;
    end
    off = (32'(off_q) > lim) ? lim : 32'(off_q);
    cyc = off + 32'(idx);
    if (cyc > lim) cyc = cyc - lim;
    dv = log_q ? 32'd256 : lim;
    c.blue = channel_byte(cyc, dv, start_q[7:0], inc_q[7:0]);
    c.green = channel_byte(cyc, dv, start_q[15:8], inc_q[15:8]);
    c.red = channel_byte(cyc, dv, start_q[23:16], inc_q[23:16]);
    c.is_inside = 1'b0;
    return c;
  endfunction

  assign pending_o = colour_q.size();

  // Track registers, queue predictions, compare results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    colour_t exp_c, got_c;
    if (!rst_ni) begin
      start_q <= StartSetRst;
      inc_q <= IncrementSetRst;
      thr_q <= ThresholdRst;
      off_q <= CycleOffsetRst;
      log_q <= 1'b0;
      inside_q <= InsideColourRst;
      colour_q.delete();
      fail_count_o <= 0;
      colours_o <= 0;
      inside_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgStartSet:     start_q <= cfg_data_i;
          CfgIncrementSet: inc_q <= cfg_data_i;
          CfgThreshold:    thr_q <= cfg_data_i[IdxW-1:0];
          CfgCycleOffset:  off_q <= cfg_data_i[IdxW-1:0];
          CfgLogMode:      log_q <= cfg_data_i[0];
          CfgInsideColour: inside_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) colour_q.push_back(predict_colour(s_data_i[IdxW-1:0]));
      if (m_valid_i && m_ready_i) begin
        got_c = {m_data_i[23:16], m_data_i[15:8], m_data_i[7:0], m_user_i[0]};
        if (colour_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h", got_c);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_c = colour_q.pop_front();
          if (got_c.is_inside) inside_o <= inside_o + 1;
          else colours_o <= colours_o + 1;
          if (got_c !== exp_c) begin
            if (fail_count_o < 10)
              $display("mismatch: expected r%h g%h b%h in%b, got r%h g%h b%h in%b",
                       exp_c.red, exp_c.green, exp_c.blue, exp_c.is_inside,
                       got_c.red, got_c.green, got_c.blue, got_c.is_inside);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/sine_palette_generator_tb.sv =====
// ----------------------------------------------------------------------------
// sine_palette_generator_tb
// Drives palette indices through several register settings and idle patterns;
// a checker beside the block predicts and compares every colour.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module sine_palette_generator_tb import spg_pkg::*;;

  logic               clk_i, rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ColW-1:0]    cfg_data_i;
  logic               s_valid, s_ready, m_valid, m_ready;
  logic [15:0]        s_data;
  logic [ColW-1:0]    m_data;
  logic [0:0]         m_user;
  int                 fail_count, pending, colours, insides;
  int                 recv_stall_pct;
  logic               hold_off;

  sine_palette_generator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user)
  );

  sine_palette_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data), .m_user_i(m_user),
    .fail_count_o(fail_count), .pending_o(pending), .colours_o(colours),
    .inside_o(insides)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("sine_palette_generator_tb NOT OK");
    $finish;
  end

  // Receiver: random stall, plus a long hold-off when asked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_ready <= 1'b0;
    else m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ColW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one index, holding it until it is taken; valid stays up for the next one
  task automatic send_index(input logic [IdxW-1:0] idx, input int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {4'd0, idx};
    do @(posedge clk_i); while (!s_ready);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain;
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (PipeLat + 4) @(posedge clk_i);
  endtask

  task automatic random_setup(input int thr_kind);
    logic [IdxW-1:0] thr;
    case (thr_kind)
      0: thr = 12'(1 + $urandom_range(40));
      1: thr = 12'hFFF;
      2: thr = 12'd0;
      default: thr = 12'($urandom_range(4095));
    endcase
    write_reg(CfgStartSet, 24'($urandom));
    write_reg(CfgIncrementSet, 24'($urandom));
    write_reg(CfgThreshold, 24'(thr));
    write_reg(CfgCycleOffset, ($urandom_range(3) == 0) ? 24'hFFF : 24'($urandom_range(4095)));
    write_reg(CfgLogMode, 24'($urandom_range(1)));
    write_reg(CfgInsideColour, 24'($urandom));
  endtask

  function automatic logic [IdxW-1:0] pick_index();
    case ($urandom_range(3))
      0: return 12'($urandom);
      1: return 12'($urandom_range(63));
      default: return 12'($urandom_range(400));
    endcase
  endfunction

  initial begin
    int              gap_pct;
    logic [IdxW-1:0] low_idx [6];
    logic [IdxW-1:0] high_idx [5];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgStartSet;
    cfg_data_i = '0;
    s_valid = 1'b0;
    s_data = '0;
    hold_off = 1'b0;
    recv_stall_pct = 0;
    low_idx = '{12'd0, 12'd1, 12'd254, 12'd255, 12'd256, 12'hFFF};
    high_idx = '{12'd0, 12'd1, 12'd4094, 12'd4095, 12'd2048};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers, edges of the index range
    foreach (low_idx[i])
      send_index(low_idx[i], 0);
    drain();
    // Zero threshold: all inside, index zero included
    write_reg(CfgThreshold, 24'd0);
    send_index(12'd0, 0);
    send_index(12'd5, 0);
    drain();
    // Large threshold and large offset, log mode, extreme registers
    write_reg(CfgThreshold, 24'hFFF);
    write_reg(CfgCycleOffset, 24'hFFF);
    write_reg(CfgLogMode, 24'd1);
    write_reg(CfgStartSet, 24'hFFFFFF);
    write_reg(CfgIncrementSet, 24'hFFFFFF);
    write_reg(CfgInsideColour, 24'hFFFFFF);
    write_reg(3'd7, 24'h123456);
    foreach (high_idx[i])
      send_index(high_idx[i], 0);
    drain();
    write_reg(CfgThreshold, 24'd1);
    write_reg(CfgCycleOffset, 24'd0);
    write_reg(CfgLogMode, 24'd0);
    write_reg(CfgStartSet, 24'd0);
    write_reg(CfgIncrementSet, 24'd0);
    write_reg(CfgInsideColour, 24'd0);
    send_index(12'd0, 0);
    send_index(12'd1, 0);
    drain();

    // Random phases over the idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      random_setup(ph % 4 == 2 && ph > 4 ? 2 : ph % 4);
      case (ph % 4)
        0: begin gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin gap_pct = 80; recv_stall_pct = 0;  end
        2: begin gap_pct = 0;  recv_stall_pct = 80; end
        default: begin gap_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 4) begin
        // Long receiver hold-off while indices keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_off = 1'b0;
          end
          for (int k = 0; k < 40; k++) send_index(pick_index(), 0);
        join
      end
      for (int k = 0; k < 75; k++) send_index(pick_index(), gap_pct);
      drain();
    end

    $display("covered %0d sine colours and %0d inside colours over twelve register settings",
             colours, insides);
    if (fail_count == 0) begin
      $display("sine_palette_generator_tb OK");
    end else begin
      $display("sine_palette_generator_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
